[rtl/core/pid_position_incremental_macros.svh]
// ---------------------------------------------------------------------------
// pid_position_incremental assertion macros
// Shared property shapes for the controller checks, clocked on clock and
// switched off while reset is high.
// ---------------------------------------------------------------------------
`ifndef PID_POSITION_INCREMENTAL_MACROS_SVH
`define PID_POSITION_INCREMENTAL_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PID_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PID_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/pid_pkg.sv]
// ---------------------------------------------------------------------------
// pid_pkg
// Types, widths and helpers shared by the PID controller and its serial
// multiply and divide units.
// ---------------------------------------------------------------------------
`default_nettype none

package pid_pkg;

   // field widths
   localparam int ERR_W      = 16;
   localparam int OUT_W      = 32;
   localparam int GAIN_W     = 24;
   localparam int DT_W       = 32;
   localparam int FRAC_W     = 16;
   localparam int INTEG_SHIFT = 32;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // serial multiplier: signed multiplicand, 32 multiplier bits, one per cycle
   localparam int MUL_A_W    = 42;
   localparam int MUL_B_W    = 32;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int MUL_S_W    = MUL_A_W + 2;
   localparam int MUL_CNT_W  = $clog2(MUL_B_W);

   // serial divider: unsigned dividend, one quotient bit per cycle
   localparam int DIV_N_W    = 42;
   localparam int DIV_D_W    = DT_W + 1;
   localparam int DIV_CNT_W  = $clog2(DIV_N_W);

   // derivative numerator, rounded product slice, term sums
   localparam int NUM_W      = DIV_N_W + 1;
   localparam int TERM_W     = 48;
   localparam int SUM_W      = 46;

   typedef struct packed {
      logic signed [ERR_W-1:0] error_sample;
      logic                    clear;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] drive;
      logic signed [OUT_W-1:0] integral;
   } rsp_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE,
      CSR_PROP_GAIN,
      CSR_INTEG_GAIN,
      CSR_DERIV_GAIN,
      CSR_SAMPLE_PERIOD
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_START,
      ST_WAIT,
      ST_SUM0,
      ST_SUM1,
      ST_OUT
   } pid_state_type;

   // clamp a wide signed sum to signed 32 bits
   function automatic logic signed [OUT_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-OUT_W:0]     top;
      logic signed [OUT_W-1:0] res;
      top = v[SUM_W-1:OUT_W-1];
      if ((&top) || !(|top)) begin
         res = v[OUT_W-1:0];
      end else if (v[SUM_W-1]) begin
         res = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(OUT_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[rtl/core/pid_serial_mul.sv]
// ---------------------------------------------------------------------------
// pid_serial_mul
// Radix-2 shift-add multiplier: one multiplier bit per cycle, LSB first,
// partial product shifted right so the adder stays multiplicand wide.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_serial_mul import pid_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [MUL_A_W-1:0]  mcand,
   input  logic        [MUL_B_W-1:0]  mplier,
   input  logic                       mplier_signed,
   output logic                       busy,
   output logic signed [MUL_P_W-1:0]  product
);

   logic                      busy_ff, busy_in;
   logic [MUL_CNT_W-1:0]      cnt_ff, cnt_in;
   logic signed [MUL_A_W-1:0] a_ff;
   logic [MUL_B_W-1:0]        b_ff;
   logic                      sgn_ff;
   logic signed [MUL_A_W:0]   hi_ff;
   logic [MUL_B_W-1:0]        lo_ff;

   logic                      last;
   logic signed [MUL_S_W-1:0] hi_ext, a_ext, sum;

   // one partial product step; the sign bit of a signed multiplier weighs negative
   always_comb begin
      last   = (cnt_ff == MUL_CNT_W'(MUL_B_W - 1));
      hi_ext = MUL_S_W'(hi_ff);
      a_ext  = MUL_S_W'(a_ff);
      if (!b_ff[0]) begin
         sum = hi_ext;
      end else if (last && sgn_ff) begin
         sum = hi_ext - a_ext;
      end else begin
         sum = hi_ext + a_ext;
      end
   end

   // step counter
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + MUL_CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operand and partial product registers
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= mcand;
         b_ff   <= mplier;
         sgn_ff <= mplier_signed;
         hi_ff  <= '0;
         lo_ff  <= '0;
      end else if (busy_ff) begin
         b_ff  <= {1'b0, b_ff[MUL_B_W-1:1]};
         hi_ff <= sum[MUL_S_W-1:1];
         lo_ff <= {sum[0], lo_ff[MUL_B_W-1:1]};
      end
   end

   assign busy    = busy_ff;
   assign product = {hi_ff[MUL_A_W-1:0], lo_ff};

endmodule

`default_nettype wire

[rtl/core/pid_serial_div.sv]
// ---------------------------------------------------------------------------
// pid_serial_div
// Restoring unsigned divider: one quotient bit per cycle, MSB first.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_serial_div import pid_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_N_W-1:0]  dividend,
   input  logic [DIV_D_W-1:0]  divisor,
   output logic                busy,
   output logic [DIV_N_W-1:0]  quotient
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]   rem_ff;
   logic [DIV_D_W-1:0]   den_ff;
   logic [DIV_N_W-1:0]   quo_ff;

   logic                 last;
   logic [DIV_D_W:0]     shifted;
   logic [DIV_D_W+1:0]   diff;
   logic                 fits;

   // trial subtract of the divisor from the shifted remainder
   always_comb begin
      last    = (cnt_ff == DIV_CNT_W'(DIV_N_W - 1));
      shifted = {rem_ff, quo_ff[DIV_N_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      fits    = !diff[DIV_D_W+1];
   end

   // step counter
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // remainder and quotient shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
         quo_ff <= {quo_ff[DIV_N_W-2:0], fits};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/core/pid_position_incremental.sv]
// ---------------------------------------------------------------------------
// pid_position_incremental
// Discrete PID controller, positional or incremental form, with saturated
// integral and drive, built on bit-serial multipliers and a serial divider.
// ---------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  req_type  (error_sample, clear)
//   rsp       out         rsp_valid / rsp_stall  rsp_type  (drive, integral)
//   csr       in          csr_valid / csr_ready  csr_index, csr_wdata
//
// An item passes these steps from accept to the next accept: three 32-step
// multipliers run side by side, then the Ki*e by dt multiply runs beside
// the 42-step derivative divider, then the sum and output states add and saturate.
// Reset is synchronous; it clears the controller state and loads the
// register defaults (dt = 1.0). A stalled result waits in the output
// register while the next item is already being worked on.
//
`default_nettype none

module pid_position_incremental import pid_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "pid_position_incremental_macros.svh"

   // configuration registers
   logic                     mode_ff;
   logic signed [GAIN_W-1:0] kp_ff, ki_ff, kd_ff;
   logic [DT_W-1:0]          dt_ff;

   // controller state
   logic signed [OUT_W-1:0]  integ_ff, prev_drive_ff;
   logic signed [ERR_W-1:0]  e1_ff, e2_ff, e_ff;

   // sequencer
   pid_state_type state_ff, state_in;
   logic accept, mul_done, load_mul, div_start, load_terms, out_free, load_out;

   // units
   logic                      mul_p_busy, mul_d_busy, mul_i_busy, div_busy;
   logic signed [MUL_P_W-1:0] mul_p_prod, mul_d_prod, mul_i_prod;
   logic signed [MUL_A_W-1:0] mul_p_a, mul_d_a, mul_i_a;
   logic [MUL_B_W-1:0]        mul_i_b;
   logic                      mul_i_start, mul_i_sgn;
   logic [DIV_N_W-1:0]        div_dividend, div_quo;
   logic [DIV_D_W-1:0]        div_divisor;

   // datapath
   logic signed [ERR_W-1:0]   e1_eff, e2_eff;
   logic signed [ERR_W:0]     diff1;
   logic signed [ERR_W+1:0]   diff2;
   logic [DT_W-1:0]           d_eff;
   logic signed [TERM_W-1:0]  p_rnd;
   logic signed [MUL_P_W-1:0] i_rnd;
   logic [NUM_W-1:0]          num_c, num_ff;
   logic [DIV_N_W:0]          q_ext, q_signed;
   logic signed [SUM_W-1:0]   p_ff, d_ff, di_ff, sum_ff, drive_base;
   logic signed [OUT_W-1:0]   integ_new_ff, drive_c;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_data_ff;

   // ---------------------------------------------------------------------
   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         kp_ff   <= '0;
         ki_ff   <= '0;
         kd_ff   <= '0;
         dt_ff   <= DT_W'(65536);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODE:          mode_ff <= csr_wdata[0];
            CSR_PROP_GAIN:     kp_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_INTEG_GAIN:    ki_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_DERIV_GAIN:    kd_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_SAMPLE_PERIOD: dt_ff   <= csr_wdata[DT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // sequencer
   always_comb begin
      state_in   = state_ff;
      req_stall  = (state_ff != ST_IDLE);
      accept     = req_valid && !req_stall;
      mul_done   = !mul_p_busy && !mul_d_busy && !mul_i_busy;
      out_free   = !rsp_valid_ff || !rsp_stall;
      load_mul   = 1'b0;
      div_start  = 1'b0;
      load_terms = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               load_mul = 1'b1;
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (!mul_i_busy && !div_busy) begin
               load_terms = 1'b1;
               state_in   = ST_SUM0;
            end
         end
         ST_SUM0: state_in = ST_SUM1;
         ST_SUM1: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------------
   // error differences, with a clear request zeroing the history first
   always_comb begin
      e1_eff = req_data.clear ? '0 : e1_ff;
      e2_eff = req_data.clear ? '0 : e2_ff;
      diff1  = (ERR_W+1)'(req_data.error_sample) - (ERR_W+1)'(e1_eff);
      diff2  = (ERR_W+2)'(req_data.error_sample) - ((ERR_W+2)'(e1_eff) <<< 1)
               + (ERR_W+2)'(e2_eff);
      mul_p_a = mode_ff ? MUL_A_W'(diff1) : MUL_A_W'(req_data.error_sample);
      mul_d_a = mode_ff ? MUL_A_W'(diff2) : MUL_A_W'(diff1);
   end

   // integral unit: Ki*e first, then that product by dt
   always_comb begin
      mul_i_start = accept || load_mul;
      if (state_ff == ST_IDLE) begin
         mul_i_a   = MUL_A_W'(req_data.error_sample);
         mul_i_b   = MUL_B_W'(ki_ff);
         mul_i_sgn = 1'b1;
      end else begin
         mul_i_a   = mul_i_prod[MUL_A_W-1:0];
         mul_i_b   = dt_ff;
         mul_i_sgn = 1'b0;
      end
   end

   pid_serial_mul u_mul_p (
      .clock         (clock),
      .reset         (reset),
      .start         (accept),
      .mcand         (mul_p_a),
      .mplier        (MUL_B_W'(kp_ff)),
      .mplier_signed (1'b1),
      .busy          (mul_p_busy),
      .product       (mul_p_prod)
   );

   pid_serial_mul u_mul_d (
      .clock         (clock),
      .reset         (reset),
      .start         (accept),
      .mcand         (mul_d_a),
      .mplier        (MUL_B_W'(kd_ff)),
      .mplier_signed (1'b1),
      .busy          (mul_d_busy),
      .product       (mul_d_prod)
   );

   pid_serial_mul u_mul_i (
      .clock         (clock),
      .reset         (reset),
      .start         (mul_i_start),
      .mcand         (mul_i_a),
      .mplier        (mul_i_b),
      .mplier_signed (mul_i_sgn),
      .busy          (mul_i_busy),
      .product       (mul_i_prod)
   );

   // ---------------------------------------------------------------------
   // derivative: floor((2*Kd*x + dt) / (2*dt)); a negative numerator n is
   // divided as ~n and the quotient inverted, which gives the floor
   always_comb begin
      d_eff        = (dt_ff == '0) ? DT_W'(1) : dt_ff;
      num_c        = {mul_d_prod[NUM_W-2:0], 1'b0} + NUM_W'(d_eff);
      div_divisor  = {d_eff, 1'b0};
      div_dividend = num_ff[NUM_W-1] ? ~num_ff[DIV_N_W-1:0] : num_ff[DIV_N_W-1:0];
      q_ext        = {1'b0, div_quo};
      q_signed     = num_ff[NUM_W-1] ? ~q_ext : q_ext;
   end

   pid_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // rounding half up of the proportional and integral products
   always_comb begin
      p_rnd = mul_p_prod[TERM_W-1:0] + TERM_W'(2 ** (FRAC_W - 1));
      i_rnd = mul_i_prod
              + {{(MUL_P_W-INTEG_SHIFT){1'b0}}, 1'b1, {(INTEG_SHIFT-1){1'b0}}};
   end

   // term registers and the running sum
   always_ff @(posedge clock) begin
      if (load_mul) begin
         p_ff   <= SUM_W'(signed'(p_rnd[TERM_W-1:FRAC_W]));
         num_ff <= num_c;
      end
      if (load_terms) begin
         d_ff  <= SUM_W'(signed'(q_signed));
         di_ff <= SUM_W'(signed'(i_rnd[MUL_P_W-1:INTEG_SHIFT]));
      end
      if (state_ff == ST_SUM0) begin
         integ_new_ff <= sat32(SUM_W'(integ_ff) + di_ff);
         sum_ff       <= p_ff + d_ff;
      end
      if (state_ff == ST_SUM1) begin
         sum_ff <= sum_ff + (mode_ff ? di_ff : SUM_W'(integ_new_ff));
      end
      if (accept) begin
         e_ff <= req_data.error_sample;
      end
   end

   // final drive: incremental form adds the previous drive
   always_comb begin
      if (mode_ff) begin
         drive_base = SUM_W'(prev_drive_ff);
      end else begin
         drive_base = '0;
      end
      drive_c = sat32(sum_ff + drive_base);
   end

   // ---------------------------------------------------------------------
   // controller state: cleared on request, advanced when the item retires
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff      <= '0;
         prev_drive_ff <= '0;
         e1_ff         <= '0;
         e2_ff         <= '0;
      end else if (accept && req_data.clear) begin
         integ_ff      <= '0;
         prev_drive_ff <= '0;
         e1_ff         <= '0;
         e2_ff         <= '0;
      end else if (load_out) begin
         integ_ff      <= integ_new_ff;
         prev_drive_ff <= drive_c;
         e1_ff         <= e_ff;
         e2_ff         <= e1_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff.drive    <= drive_c;
         rsp_data_ff.integral <= integ_new_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // checks
   `PID_ASSERT_SAME(a_idle_units_quiet, !req_stall,
      (!mul_p_busy && !mul_d_busy && !mul_i_busy && !div_busy),
      "arithmetic unit busy while the controller takes items")
   `PID_ASSERT_NEXT(a_accept_starts_mul, (req_valid && !req_stall),
      (state_ff == ST_MUL && mul_p_busy && mul_d_busy && mul_i_busy),
      "accepted item did not start the multipliers")
   `PID_ASSERT_SAME(a_div_after_mul, div_busy,
      (!mul_p_busy && !mul_d_busy),
      "divider running before the derivative product is ready")
   `PID_ASSERT_NEXT(a_retire_loads_output, load_out,
      (rsp_valid_ff && state_ff == ST_IDLE),
      "retired item not presented on the result channel")

endmodule

`default_nettype wire
